// ----- rtl/core/fxa_pkg.sv -----
// fxa_pkg: shared types and codes for the fixed-point alu core
// no dependencies
`default_nettype none
package fxa_pkg;
    localparam int W = 32;
    localparam int F = 8;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
        OP_EQ = 4'd8, OP_NE = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
        OP_MIN = 4'd12, OP_MAX = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
    } op_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic [3:0] kind;
        logic signed [W-1:0] operand_a;
        logic signed [W-1:0] operand_b;
    } in_t;

    typedef struct packed {
        logic signed [W-1:0] result_word;
        logic truth;
        logic [1:0] status;
    } out_t;

    // classified transaction handed from front to back
    typedef struct packed {
        logic [3:0] kind;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic neg;
        logic [W-1:0] ma;
        logic [W-1:0] mb;
    } cls_t;
endpackage
`default_nettype wire

// ----- rtl/core/fxa_front.sv -----
// fxa_front: accepts transactions, classifies and takes magnitudes
// depends on fxa_pkg
`default_nettype none
module fxa_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire fxa_pkg::in_t  s_data,
    output logic               c_valid,
    input  wire logic          c_ready,
    output fxa_pkg::cls_t      c_data
);
    localparam int W = fxa_pkg::W;
    logic [W-1:0] a, b;
    fxa_pkg::cls_t q_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign a = s_data.operand_a;
    assign b = s_data.operand_b;
    assign s_ready = cnt_reg != 2'd2;
    assign c_valid = cnt_reg != 2'd0;
    assign c_data = q_reg[rp_reg];
    assign push = s_valid && s_ready;
    assign pop = c_valid && c_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            q_reg[wp_reg].kind <= s_data.kind;
            q_reg[wp_reg].a <= a;
            q_reg[wp_reg].b <= b;
            q_reg[wp_reg].neg <= a[W-1] ^ b[W-1];
            q_reg[wp_reg].ma <= a[W-1] ? (~a + 1'b1) : a;
            q_reg[wp_reg].mb <= b[W-1] ? (~b + 1'b1) : b;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !s_ready)
        else $error("accepted into full queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !c_valid)
        else $error("empty queue presents data");
endmodule
`default_nettype wire

// ----- rtl/core/fxa_back.sv -----
// fxa_back: pipelined execution of classified transactions; depends on fxa_pkg
// multiply in first and last stage, divide one quotient bit per stage
`default_nettype none
module fxa_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          c_valid,
    output logic               c_ready,
    input  wire fxa_pkg::cls_t c_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output fxa_pkg::out_t      m_data
);
    localparam int W = fxa_pkg::W;
    localparam int F = fxa_pkg::F;
    localparam int NB = W + F;          // numerator bits
    localparam int D = NB + 2;          // stages
    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [3:0] kind;
        logic [W-1:0] a;
        logic neg;
        logic [W-1:0] d;
        logic [NB-1:0] num;
        logic [W:0] rem;
        logic [NB-1:0] quo;
        logic [2*W-1:0] prod;
        logic [W-1:0] res;
        logic truth;
        logic [1:0] st;
    } stg_t;

    stg_t p_reg [D];
    logic v_reg [D];
    logic adv;
    stg_t s0;
    logic [W-1:0] a, b, r;
    logic [W:0] wide;
    logic ovf, lt;

    // output stall: pipeline advances when last slot is empty or taken
    assign adv = !v_reg[D-1] || m_ready;
    assign c_ready = adv;
    assign m_valid = v_reg[D-1];

    function automatic logic [W-1:0] sat(input logic neg);
        sat = neg ? MINN : MAXP;
    endfunction

    always_comb begin
        a = c_data.a;
        b = c_data.b;
        lt = $signed(a) < $signed(b);
        s0 = '0;
        s0.kind = c_data.kind;
        s0.a = a;
        s0.neg = c_data.neg;
        s0.d = c_data.mb;
        s0.num = {c_data.ma, {F{1'b0}}};
        s0.st = fxa_pkg::ST_OK;
        wide = '0;
        r = '0;
        ovf = 1'b0;
        case (fxa_pkg::op_t'(c_data.kind))
            fxa_pkg::OP_ADD, fxa_pkg::OP_INC: begin
                r = a + ((c_data.kind == fxa_pkg::OP_ADD) ? b : {{(W-1){1'b0}}, 1'b1});
                ovf = (a[W-1] == ((c_data.kind == fxa_pkg::OP_ADD) ? b[W-1] : 1'b0))
                    && (r[W-1] != a[W-1]);
                s0.res = ovf ? sat(a[W-1]) : r;
                s0.st = ovf ? fxa_pkg::ST_OVF : fxa_pkg::ST_OK;
            end
            fxa_pkg::OP_SUB, fxa_pkg::OP_DEC: begin
                r = a - ((c_data.kind == fxa_pkg::OP_SUB) ? b : {{(W-1){1'b0}}, 1'b1});
                ovf = (a[W-1] != ((c_data.kind == fxa_pkg::OP_SUB) ? b[W-1] : 1'b0))
                    && (r[W-1] != a[W-1]);
                s0.res = ovf ? sat(a[W-1]) : r;
                s0.st = ovf ? fxa_pkg::ST_OVF : fxa_pkg::ST_OK;
            end
            fxa_pkg::OP_MUL: s0.prod = c_data.ma * c_data.mb;
            fxa_pkg::OP_DIV: begin
                if (b == '0) begin
                    s0.res = sat(a[W-1]);
                    s0.st = fxa_pkg::ST_DIV0;
                end
            end
            fxa_pkg::OP_GT: s0.truth = $signed(b) < $signed(a);
            fxa_pkg::OP_LT: s0.truth = lt;
            fxa_pkg::OP_GE: s0.truth = !lt;
            fxa_pkg::OP_LE: s0.truth = !($signed(b) < $signed(a));
            fxa_pkg::OP_EQ: s0.truth = a == b;
            fxa_pkg::OP_NE: s0.truth = a != b;
            fxa_pkg::OP_MIN: s0.res = lt ? a : b;
            fxa_pkg::OP_MAX: s0.res = ($signed(b) < $signed(a)) ? a : b;
            fxa_pkg::OP_FROM_INT: begin
                wide = {1'b0, c_data.ma};
                // a positive value at the limit still overflows after the shift
                ovf = (wide > ({1'b0, MINN} >> F))
                    || (!a[W-1] && (wide == ({1'b0, MINN} >> F)));
                s0.res = ovf ? sat(a[W-1]) : (a << F);
                s0.st = ovf ? fxa_pkg::ST_OVF : fxa_pkg::ST_OK;
            end
            default: s0.res = $signed(a) >>> F;
        endcase
    end

    // divide step: one restoring bit per stage
    function automatic stg_t dstep(input stg_t x);
        stg_t y;
        logic [W:0] t;
        y = x;
        t = {x.rem[W-1:0], x.num[NB-1]};
        y.num = x.num << 1;
        if (t >= {1'b0, x.d}) begin
            y.rem = t - {1'b0, x.d};
            y.quo = {x.quo[NB-2:0], 1'b1};
        end else begin
            y.rem = t;
            y.quo = {x.quo[NB-2:0], 1'b0};
        end
        return y;
    endfunction

    // final stage: rounding and saturation for mul and div
    function automatic stg_t fin(input stg_t x);
        stg_t y;
        logic [2*W-1:0] pr;
        logic [NB:0] q;
        logic [W:0] dr;
        logic hi;
        logic [W-1:0] mag;
        y = x;
        pr = x.prod + ({{(2*W-1){1'b0}}, 1'b1} << (F - 1));
        dr = {1'b0, x.d} - x.rem;
        q = {1'b0, x.quo} + {{NB{1'b0}}, (x.rem >= dr)};
        hi = 1'b0;
        mag = '0;
        if (x.kind == fxa_pkg::OP_MUL) begin
            hi = (pr < x.prod) || (|pr[2*W-1:W+F]);
            mag = pr[W+F-1:F];
        end else begin
            hi = |q[NB:W];
            mag = q[W-1:0];
        end
        if (x.kind == fxa_pkg::OP_MUL || (x.kind == fxa_pkg::OP_DIV
                && x.st != fxa_pkg::ST_DIV0)) begin
            if (hi || (!x.neg && mag[W-1]) || (x.neg && mag > MINN)) begin
                y.res = sat(x.neg);
                y.st = fxa_pkg::ST_OVF;
            end else begin
                y.res = x.neg ? (~mag + 1'b1) : mag;
                y.st = fxa_pkg::ST_OK;
            end
        end
        return y;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < D; i++) v_reg[i] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= c_valid;
            for (int i = 1; i < D; i++) v_reg[i] <= v_reg[i-1];
        end
        if (adv) begin
            p_reg[0] <= s0;
            for (int i = 1; i < D - 1; i++) p_reg[i] <= dstep(p_reg[i-1]);
            p_reg[D-1] <= fin(p_reg[D-2]);
        end
    end

    assign m_data.result_word = p_reg[D-1].res;
    assign m_data.truth = p_reg[D-1].truth;
    assign m_data.status = p_reg[D-1].st;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3)
        else $error("bad status code");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.truth) |-> (m_data.result_word == '0))
        else $error("comparison with nonzero word");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped under stall");
endmodule
`default_nettype wire

// ----- rtl/core/fixed_point_q24_8_alu_core.sv -----
// Signed Q24.8 fixed-point ALU. Accepts one transaction per cycle unless the
// receiver stalls the output. Results pass a front queue of two entries, then
// a back pipeline sized by the divide array, one quotient bit per stage.
`default_nettype none
module fixed_point_q24_8_alu_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire fxa_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output fxa_pkg::out_t      m_data
);
    logic c_valid, c_ready;
    fxa_pkg::cls_t c_data;

    fxa_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .c_valid(c_valid), .c_ready(c_ready), .c_data(c_data)
    );

    fxa_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .c_valid(c_valid), .c_ready(c_ready), .c_data(c_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule
`default_nettype wire

// ----- tb/alu_scoreboard.sv -----
// alu_scoreboard: predicts q24.8 alu results and checks them in order
// depends on fxa_pkg
`timescale 1ns / 1ps
class alu_scoreboard;
    fxa_pkg::out_t pending[$];
    int errors;
    int checked;
    int op_count[16];

    function new();
        errors = 0;
        checked = 0;
        foreach (op_count[i]) op_count[i] = 0;
    endfunction

    static function logic [31:0] sat_by(bit neg);
        return neg ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    // saturate a signed wide value into the word range
    static function void clamp(logic signed [127:0] v, output logic [31:0] r,
                               output logic [1:0] st);
        if (v > 128'sh7fff_ffff) begin
            r = 32'h7fff_ffff;
            st = fxa_pkg::ST_OVF;
        end else if (v < -128'sh8000_0000) begin
            r = 32'h8000_0000;
            st = fxa_pkg::ST_OVF;
        end else begin
            r = v[31:0];
            st = fxa_pkg::ST_OK;
        end
    endfunction

    static function fxa_pkg::out_t compute(fxa_pkg::in_t t);
        fxa_pkg::out_t o;
        logic signed [127:0] a, b, v, mag_n, mag_d, q, rem;
        logic [31:0] r;
        logic [1:0] st;
        bit neg;
        a = 128'(signed'(t.operand_a));
        b = 128'(signed'(t.operand_b));
        r = 0;
        st = fxa_pkg::ST_OK;
        o.truth = 0;
        case (fxa_pkg::op_t'(t.kind))
            fxa_pkg::OP_ADD: clamp(a + b, r, st);
            fxa_pkg::OP_SUB: clamp(a - b, r, st);
            fxa_pkg::OP_INC: clamp(a + 1, r, st);
            fxa_pkg::OP_DEC: clamp(a - 1, r, st);
            fxa_pkg::OP_MUL: begin
                neg = (a < 0) != (b < 0);
                v = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + 128) >>> 8;
                clamp(neg ? -v : v, r, st);
            end
            fxa_pkg::OP_DIV: begin
                if (b == 0) begin
                    r = sat_by(a < 0);
                    st = fxa_pkg::ST_DIV0;
                end else begin
                    neg = (a < 0) != (b < 0);
                    mag_n = (a < 0 ? -a : a) <<< 8;
                    mag_d = b < 0 ? -b : b;
                    q = mag_n / mag_d;
                    rem = mag_n % mag_d;
                    if (rem >= mag_d - rem) q = q + 1;
                    clamp(neg ? -q : q, r, st);
                end
            end
            fxa_pkg::OP_GT: o.truth = a > b;
            fxa_pkg::OP_LT: o.truth = a < b;
            fxa_pkg::OP_GE: o.truth = a >= b;
            fxa_pkg::OP_LE: o.truth = a <= b;
            fxa_pkg::OP_EQ: o.truth = a == b;
            fxa_pkg::OP_NE: o.truth = a != b;
            fxa_pkg::OP_MIN: r = (a < b) ? t.operand_a : t.operand_b;
            fxa_pkg::OP_MAX: r = (b < a) ? t.operand_a : t.operand_b;
            fxa_pkg::OP_FROM_INT: clamp(a * 256, r, st);
            default: r = 32'(t.operand_a >>> 8);
        endcase
        o.result_word = r;
        o.status = st;
        return o;
    endfunction

    function void note_input(fxa_pkg::in_t t);
        pending.push_back(compute(t));
        op_count[t.kind]++;
    endfunction

    function void check_result(fxa_pkg::out_t got);
        fxa_pkg::out_t exp;
        if (pending.size() == 0) begin
            $error("result with no transaction outstanding: %h", got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        checked++;
        if (got.result_word !== exp.result_word) begin
            $error("result_word expected %h actual %h", exp.result_word, got.result_word);
            errors++;
        end
        if (got.truth !== exp.truth) begin
            $error("truth expected %b actual %b", exp.truth, got.truth);
            errors++;
        end
        if (got.status !== exp.status) begin
            $error("status expected %0d actual %0d", exp.status, got.status);
            errors++;
        end
    endfunction
endclass

// ----- tb/tb_top.sv -----
// tb_top: directed and random regression of fixed_point_q24_8_alu_core
// depends on fxa_pkg, alu_scoreboard and the core rtl
`timescale 1ns / 1ps
module tb_top;
    localparam int RANDOM_ITEMS = 1530;
    localparam int LATENCY = 42;
    localparam int STALL_LIMIT = 5000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    fxa_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    fxa_pkg::out_t m_data;

    alu_scoreboard board = new();
    bit quiet_mode = 0;
    bit hold_off = 0;
    int idle_cycles = 0;

    fixed_point_q24_8_alu_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 3) - 1;
            3: return 32'(signed'($urandom_range(0, 4096)) - 2048);
            4: return 32'(signed'($urandom_range(0, 65535)) - 32768);
            5: return 32'(signed'($urandom_range(0, 2 ** 24)) - 2 ** 23);
            default: return $urandom();
        endcase
    endfunction

    task automatic send(fxa_pkg::op_t op, logic [31:0] a, logic [31:0] b);
        if (!quiet_mode)
            while ($urandom_range(0, 99) < 25) begin
                s_valid <= 0;
                @(negedge aclk);
            end
        s_data <= '{kind: op, operand_a: a, operand_b: b};
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_input(s_data);
        @(negedge aclk);
    endtask

    // receiver
    always @(negedge aclk) begin
        if (hold_off) m_ready <= 0;
        else if (quiet_mode) m_ready <= 1;
        else m_ready <= ($urandom_range(0, 99) >= 25);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("fixed_point_q24_8_alu_core regression: fail");
            $finish;
        end
    end

    initial begin
        logic [31:0] edges[6];
        edges = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h100, 32'hffff_ff00};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // directed corners
        send(fxa_pkg::OP_ADD, 32'h7fff_ffff, 32'h1);
        send(fxa_pkg::OP_SUB, 32'h8000_0000, 32'h1);
        send(fxa_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
        send(fxa_pkg::OP_MUL, 32'h8000_0000, 32'h100);
        send(fxa_pkg::OP_MUL, 32'hffff_ffff, 32'h80);
        send(fxa_pkg::OP_DIV, 32'h100, 32'h0);
        send(fxa_pkg::OP_DIV, 32'h8000_0000, 32'h0);
        send(fxa_pkg::OP_DIV, 32'h0, 32'h0);
        send(fxa_pkg::OP_DIV, 32'h8000_0000, 32'h1);
        send(fxa_pkg::OP_DIV, 32'h1, 32'h200);
        send(fxa_pkg::OP_DIV, 32'hffff_ffff, 32'h200);
        send(fxa_pkg::OP_GT, 32'h8000_0000, 32'h7fff_ffff);
        send(fxa_pkg::OP_LT, 32'h8000_0000, 32'h7fff_ffff);
        send(fxa_pkg::OP_GE, 32'h5, 32'h5);
        send(fxa_pkg::OP_LE, 32'h5, 32'h5);
        send(fxa_pkg::OP_EQ, 32'h5, 32'h5);
        send(fxa_pkg::OP_NE, 32'h5, 32'h5);
        send(fxa_pkg::OP_INC, 32'h7fff_ffff, 32'h0);
        send(fxa_pkg::OP_DEC, 32'h8000_0000, 32'hffff_ffff);
        send(fxa_pkg::OP_MIN, 32'h7, 32'h7);
        send(fxa_pkg::OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
        send(fxa_pkg::OP_FROM_INT, 32'h0080_0000, 32'h0);
        send(fxa_pkg::OP_FROM_INT, 32'hff80_0000, 32'h0);
        send(fxa_pkg::OP_FROM_INT, 32'hff7f_ffff, 32'h0);
        send(fxa_pkg::OP_TO_INT, 32'hffff_ffff, 32'h0);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            logic [31:0] a, b;
            quiet_mode = (i >= 300 && i < 500);
            if (i == 700) hold_off = 1;
            if ($urandom_range(0, 9) == 0) begin
                a = edges[$urandom_range(0, 5)];
                b = edges[$urandom_range(0, 5)];
            end else begin
                a = pick_word();
                b = ($urandom_range(0, 7) == 0) ? a : pick_word();
            end
            send(fxa_pkg::op_t'($urandom_range(0, 15)), a, b);
        end
        s_valid <= 0;
        quiet_mode = 0;
        hold_off = 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("ran %0d transactions over all 16 operations, %0d results checked",
                 RANDOM_ITEMS + 25, board.checked);
        $display("included saturation, divide by zero and a long receiver hold-off");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("fixed_point_q24_8_alu_core regression: pass");
        else
            $display("fixed_point_q24_8_alu_core regression: fail");
        $finish;
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (hold_off);
        repeat (400) @(negedge aclk);
        hold_off = 0;
    end
endmodule
